FILE: hdl/rmud_pkg.sv
// ----------------------------------------------------------------------------
// rmud_pkg: shared types and constants for the radio module UART deframer
// Result item layout, configuration bundle, frame constants and helpers.
// ----------------------------------------------------------------------------
package rmud_pkg;

	// Result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_DROP = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_RSSI_EN  = 2'd0;
	localparam logic [1:0] CFG_DATA_IND = 2'd1;
	localparam logic [1:0] CFG_GAP      = 2'd2;

	// Frame constants
	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] TGRAM_CFIELD = 8'h44;
	localparam logic [7:0] TGRAM_MINLEN = 8'd10;
	localparam logic [8:0] RSSI_OFFSET  = 9'd74;
	localparam logic [8:0] RSSI_WRAP    = 9'd256;

	typedef struct packed {
		logic              rssi_enabled;
		logic [6:0]        data_indication_code;
		logic [15:0]       gap_limit;
	} rmud_cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        payload_byte;
		logic [7:0]        message_id;
		logic signed [8:0] signal_dbm;
		logic              rssi_valid;
		logic              checksum_ok;
		logic              last_of_step;
	} rmud_result_t;

	// Up to two results per item, pushed into the result queue together
	typedef struct packed {
		logic [1:0]        count;
		rmud_result_t      r0;
		rmud_result_t      r1;
	} rmud_push_t;

	// Raw RSSI byte as signed value, halved toward zero, minus 74
	function automatic logic signed [8:0] rssi_to_dbm(input logic [7:0] raw);
		logic [8:0] mag;
		logic [8:0] res;
		mag = RSSI_WRAP - {1'b0, raw};
		if (raw[7]) begin
			res = 9'd0 - {1'b0, mag[8:1]} - RSSI_OFFSET;
		end else begin
			res = {2'b00, raw[7:1]} - RSSI_OFFSET;
		end
		return $signed(res);
	endfunction

	function automatic rmud_result_t byte_result(input logic [7:0] b);
		rmud_result_t r;
		r = '0;
		r.kind = KIND_BYTE;
		r.payload_byte = b;
		return r;
	endfunction

	function automatic rmud_result_t done_result(input logic [7:0] mid, input logic ok,
		input logic has_rssi, input logic [7:0] raw);
		rmud_result_t r;
		r = '0;
		r.kind = KIND_DONE;
		r.message_id = mid;
		r.checksum_ok = ok;
		r.rssi_valid = has_rssi;
		r.signal_dbm = has_rssi ? rssi_to_dbm(raw) : 9'sd0;
		return r;
	endfunction

endpackage

FILE: hdl/rmud_core.sv
// ----------------------------------------------------------------------------
// rmud_core: frame state and per-item parse logic
// Holds the frame tracking state and builds the results of one item.
// ----------------------------------------------------------------------------
module rmud_core import rmud_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       mode_s1,
	input  logic [7:0] rx_byte_s1,
	input  rmud_cfg_t  cfg,
	output rmud_push_t push
);

	typedef enum logic [2:0] {
		PH_EMPTY,
		PH_HELD,
		PH_CODE,
		PH_LEN,
		PH_BODY,
		PH_RSSI,
		PH_SUM,
		PH_TGRAM
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  held_q, held_d;
	logic [7:0]  code_q, code_d;
	logic [8:0]  left_q, left_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  rssi_raw_q, rssi_raw_d;
	logic        expect_q, expect_d;
	logic [15:0] sil_q, sil_d;
	logic [15:0] sil_inc;
	logic [1:0]  n;
	rmud_result_t r0, r1;

	assign sil_inc = (sil_q != 16'hFFFF) ? sil_q + 16'd1 : sil_q;

	always_comb begin
		phase_d    = phase_q;
		held_d     = held_q;
		code_d     = code_q;
		left_d     = left_q;
		xor_d      = xor_q;
		rssi_raw_d = rssi_raw_q;
		expect_d   = expect_q;
		sil_d      = sil_q;
		r0 = '0;
		r1 = '0;
		n  = 2'd0;
		if (mode_s1) begin
			if (phase_q != PH_EMPTY) begin
				sil_d = sil_inc;
				if (sil_inc >= cfg.gap_limit) begin
					r0.kind = KIND_DROP;
					n       = 2'd1;
					phase_d = PH_EMPTY;
					sil_d   = 16'd0;
				end
			end
		end else begin
			sil_d = 16'd0;
			case (phase_q)
				PH_EMPTY: begin
					held_d  = rx_byte_s1;
					phase_d = (rx_byte_s1 == SYNC_BYTE) ? PH_CODE : PH_HELD;
				end
				PH_HELD: begin
					if (held_q >= TGRAM_MINLEN && rx_byte_s1 == TGRAM_CFIELD) begin
						expect_d = cfg.rssi_enabled;
						r0       = byte_result(held_q);
						r1       = byte_result(rx_byte_s1);
						n        = 2'd2;
						left_d   = {1'b0, held_q} - 9'd1;
						phase_d  = PH_TGRAM;
					end else begin
						held_d  = rx_byte_s1;
						phase_d = (rx_byte_s1 == SYNC_BYTE) ? PH_CODE : PH_HELD;
					end
				end
				PH_CODE: begin
					code_d   = rx_byte_s1;
					xor_d    = SYNC_BYTE ^ rx_byte_s1;
					expect_d = cfg.rssi_enabled &&
						(rx_byte_s1 == {1'b1, cfg.data_indication_code});
					phase_d  = PH_LEN;
				end
				PH_LEN: begin
					xor_d = xor_q ^ rx_byte_s1;
					if (rx_byte_s1 != 8'd0) begin
						r0      = byte_result(rx_byte_s1);
						n       = 2'd1;
						left_d  = {1'b0, rx_byte_s1};
						phase_d = PH_BODY;
					end else begin
						phase_d = expect_q ? PH_RSSI : PH_SUM;
					end
				end
				PH_BODY: begin
					xor_d  = xor_q ^ rx_byte_s1;
					r0     = byte_result(rx_byte_s1);
					n      = 2'd1;
					left_d = left_q - 9'd1;
					if (left_q == 9'd1) begin
						phase_d = expect_q ? PH_RSSI : PH_SUM;
					end
				end
				PH_RSSI: begin
					xor_d      = xor_q ^ rx_byte_s1;
					rssi_raw_d = rx_byte_s1;
					phase_d    = PH_SUM;
				end
				PH_SUM: begin
					r0      = done_result(code_q, xor_q == rx_byte_s1, expect_q, rssi_raw_q);
					n       = 2'd1;
					phase_d = PH_EMPTY;
				end
				PH_TGRAM: begin
					r0     = byte_result(rx_byte_s1);
					n      = 2'd1;
					left_d = left_q - 9'd1;
					if (left_q == 9'd1) begin
						rssi_raw_d = rx_byte_s1;
						r1         = done_result(8'd0, 1'b1, expect_q, rx_byte_s1);
						n          = 2'd2;
						phase_d    = PH_EMPTY;
					end
				end
				default: begin
					phase_d = PH_EMPTY;
				end
			endcase
		end
		// flag the final result of this item
		if (n == 2'd1) begin
			r0.last_of_step = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last_of_step = 1'b1;
		end
	end

	assign push.count = step ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_EMPTY;
			held_q     <= 8'd0;
			code_q     <= 8'd0;
			left_q     <= 9'd0;
			xor_q      <= 8'd0;
			rssi_raw_q <= 8'd0;
			expect_q   <= 1'b0;
			sil_q      <= 16'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			held_q     <= held_d;
			code_q     <= code_d;
			left_q     <= left_d;
			xor_q      <= xor_d;
			rssi_raw_q <= rssi_raw_d;
			expect_q   <= expect_d;
			sil_q      <= sil_d;
		end
	end

endmodule

FILE: hdl/rmud_queue.sv
// ----------------------------------------------------------------------------
// rmud_queue: four-entry result queue
// Takes up to two results per cycle, hands out one per output handshake.
// ----------------------------------------------------------------------------
module rmud_queue import rmud_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  rmud_push_t   push,
	input  logic         out_ready,
	output logic         out_valid,
	output rmud_result_t head,
	output logic         room
);

	rmud_result_t mem_q [4];
	logic [1:0]   wr_ptr_q;
	logic [1:0]   rd_ptr_q;
	logic [2:0]   count_q;
	logic         pop;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	// two free slots needed before the next item may be parsed
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule

FILE: hdl/radio_module_uart_deframer.sv
// ----------------------------------------------------------------------------
// radio_module_uart_deframer: splits a radio module UART byte stream into frames
// Command frames and telegrams out as byte items plus a completion item.
// ----------------------------------------------------------------------------
// Feed one item per cycle: a received byte (mode 0) or a time tick (mode 1).
// The block takes a new item every cycle while the result queue has room; the
// first result of an item passes through the input register and then the
// result queue before it shows on the output. Most items give zero or one
// result; opening a telegram and its last byte give two, which leave the
// output one per cycle while out_ready is high. Input stalls only when
// the four-entry result queue has fewer than two free slots, so throughput is
// set by how fast the consumer drains results. Command frames are FF, cmd,
// len, payload, optional RSSI, XOR checksum; telegrams open on a length of 10
// or more followed by 0x44. rssi_enabled and data_indication_code are sampled
// when a frame opens. A run of gap_limit ticks with a partial frame drops it
// with a single drop item. Write configuration only while the block is idle.
module radio_module_uart_deframer import rmud_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	// result items
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [7:0]        payload_byte,
	output logic [7:0]        message_id,
	output logic signed [8:0] signal_dbm,
	output logic              rssi_valid,
	output logic              checksum_ok,
	output logic              last_of_step,
	// configuration writes
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata
);

	rmud_cfg_t    cfg_q;
	logic         valid_s1;
	logic         mode_s1;
	logic [7:0]   rx_byte_s1;
	logic         fire;
	logic         room;
	rmud_push_t   push;
	rmud_result_t head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rssi_enabled         <= 1'b1;
			cfg_q.data_indication_code <= 7'd3;
			cfg_q.gap_limit            <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RSSI_EN:  cfg_q.rssi_enabled         <= cfg_wdata[0];
				CFG_DATA_IND: cfg_q.data_indication_code <= cfg_wdata[6:0];
				CFG_GAP:      cfg_q.gap_limit            <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Input register: parse the held item once the queue has room
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1    <= mode;
			rx_byte_s1 <= rx_byte;
		end
	end

	rmud_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.mode_s1    (mode_s1),
		.rx_byte_s1 (rx_byte_s1),
		.cfg        (cfg_q),
		.push       (push)
	);

	rmud_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	// Drive the result fields from the queue head
	assign kind         = head.kind;
	assign payload_byte = head.payload_byte;
	assign message_id   = head.message_id;
	assign signal_dbm   = head.signal_dbm;
	assign rssi_valid   = head.rssi_valid;
	assign checksum_ok  = head.checksum_ok;
	assign last_of_step = head.last_of_step;

	// A two-result item marks only its second result as last
	a_last_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !push.r0.last_of_step && push.r1.last_of_step)
		else $error("two-result item carries a wrong last flag");

	// A drop comes only from a tick and alone
	a_drop_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0 && push.r0.kind == KIND_DROP) |-> mode_s1 && push.count == 2'd1)
		else $error("drop result from a data byte or with a companion");

	// Results appear only after an item was parsed
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("result appeared without a parsed item");

endmodule
